// ----- rtl/gregorian_ordinal_date_convert_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian ordinal date converter
// Concurrent checks on clk, disabled while rst is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_ORDINAL_DATE_CONVERT_ASSERT_SVH
`define GREGORIAN_ORDINAL_DATE_CONVERT_ASSERT_SVH
`ifndef SYNTHESIS
`define GOCD_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gocd: same-cycle check failed");
`define GOCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gocd: next-cycle check failed");
`else
`define GOCD_ASSERT_IMPLIES(label, ante, cons)
`define GOCD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/gocd_pkg.sv -----
// ----------------------------------------------------------------------------
// Gregorian ordinal date converter package
// Calendar constants, reciprocal factors, status codes and lane result type.
// ----------------------------------------------------------------------------
package gocd_pkg;

  localparam int LANE_DEPTH = 10;
  localparam int OUT_DEPTH  = 3;
  localparam int PIPE_DEPTH = LANE_DEPTH + OUT_DEPTH;

  localparam logic [21:0] MAX_ORD   = 22'd3652059;
  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [10:0] DAYS_4Y   = 11'd1461;
  localparam logic [8:0]  DAYS_1Y   = 9'd365;

  // Reciprocal factors floor(2^k / d); k is 22, 18, 16, 11, 14, 14 and 22.
  localparam logic [4:0]  RCP_400Y = 5'd28;
  localparam logic [2:0]  RCP_100Y = 3'd7;
  localparam logic [5:0]  RCP_4Y   = 6'd44;
  localparam logic [2:0]  RCP_1Y   = 3'd5;
  localparam logic [7:0]  RCP_C100 = 8'd163;
  localparam logic [5:0]  RCP_C400 = 6'd40;
  localparam logic [19:0] RCP_WEEK = 20'd599186;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_BAD_ORD  = 2'd2
  } status_t;

  typedef struct packed {
    logic        err;
    logic [21:0] ordinal;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_res_t;

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:                                        r = 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/gregorian_ordinal_date_convert.sv -----
// ----------------------------------------------------------------------------
// Gregorian ordinal date converter
// Throughput: one request per cycle while the result side does not stall; the 10-stage ordinal split sets depth.
// Bubbles collapse: a stage loads whenever it is empty or its successor moves.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`include "gregorian_ordinal_date_convert_assert.svh"

module gregorian_ordinal_date_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // in_year[13:0], in_month[17:14], in_day[22:18],
                                 // in_ordinal[44:23], zero fill[47:45]
  input  logic [0:0]  s_tuser,   // mode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_ordinal[21:0], out_year[35:22], out_month[39:36],
                                 // out_day[44:40], out_weekday[47:45]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int LD = gocd_pkg::LANE_DEPTH;
  localparam int PD = gocd_pkg::PIPE_DEPTH;

  logic [PD-1:0]       v, en;
  logic [LD-1:0]       mode_pipe;
  gocd_pkg::date_res_t d2o_res, o2d_res;
  logic [21:0]         ordinal;
  logic [13:0]         year;
  logic [3:0]          month;
  logic [4:0]          day;
  logic [2:0]          weekday;
  gocd_pkg::status_t   status;

  always_comb begin
    en[PD-1] = !v[PD-1] || m_tready;
    for (int i = PD - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < PD; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode_pipe[0] <= s_tuser[0];
    end
    for (int i = 1; i < LD; i++) begin
      if (en[i]) begin
        mode_pipe[i] <= mode_pipe[i-1];
      end
    end
  end

  gocd_d2o u_d2o (
    .clk   (clk),
    .en    (en[LD-1:0]),
    .year  (s_tdata[13:0]),
    .month (s_tdata[17:14]),
    .day   (s_tdata[22:18]),
    .res   (d2o_res)
  );

  gocd_o2d u_o2d (
    .clk     (clk),
    .en      (en[LD-1:0]),
    .ordinal (s_tdata[44:23]),
    .res     (o2d_res)
  );

  gocd_wday u_wday (
    .clk     (clk),
    .en      (en[PD-1:LD]),
    .mode    (mode_pipe[LD-1]),
    .d2o     (d2o_res),
    .o2d     (o2d_res),
    .ordinal (ordinal),
    .year    (year),
    .month   (month),
    .day     (day),
    .weekday (weekday),
    .status  (status)
  );

  assign s_tready = en[0];
  assign m_tvalid = v[PD-1];
  assign m_tdata  = {weekday, day, month, year, ordinal};
  assign m_tuser  = status;

  `GOCD_ASSERT_IMPLIES(a_ok_fields, m_tvalid && (status == gocd_pkg::ST_OK), (month != 4'd0) && (month <= 4'd12) && (day != 5'd0) && (weekday <= 3'd6) && (year != 14'd0))
  `GOCD_ASSERT_IMPLIES(a_err_zero, m_tvalid && (status != gocd_pkg::ST_OK), m_tdata == 48'd0)
  `GOCD_ASSERT_IMPLIES(a_ord_bound, m_tvalid, ordinal <= gocd_pkg::MAX_ORD)
  `GOCD_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v[0])

endmodule

// ----- rtl/gocd_d2o.sv -----
// ----------------------------------------------------------------------------
// Date to ordinal lane
// Checks a year, month and day and sums the days before it, then delays the
// result to the common lane depth.
// ----------------------------------------------------------------------------
module gocd_d2o (
  input  logic                              clk,
  input  logic [gocd_pkg::LANE_DEPTH-1:0]   en,
  input  logic [13:0]                       year,
  input  logic [3:0]                        month,
  input  logic [4:0]                        day,
  output gocd_pkg::date_res_t               res
);

  localparam int DLY = gocd_pkg::LANE_DEPTH - 4;

  logic [13:0] p_c;
  logic [21:0] prod100_c;
  logic [19:0] prod400_c;
  logic        ok_c;

  logic [13:0] y1, p1;
  logic [3:0]  m1;
  logic [4:0]  d1;
  logic        ok1;
  logic [6:0]  q100e1;
  logic [4:0]  q400e1;

  logic [13:0] y2, p2;
  logic [3:0]  m2;
  logic [4:0]  d2;
  logic        ok2;
  logic [6:0]  q100e2;
  logic [4:0]  q400e2;
  logic [7:0]  r100_2;
  logic [9:0]  r400_2;

  logic        c100_c, c400_c, leap_c;
  logic [7:0]  r100_c;
  logic [9:0]  r400_c;
  logic [4:0]  mdays_c;

  logic [13:0] y3;
  logic [3:0]  m3;
  logic [4:0]  d3;
  logic        ok3;
  logic [6:0]  q100_3;
  logic [4:0]  q400_3;
  logic [11:0] q4_3;
  logic [21:0] p365_3;
  logic [9:0]  doy_3;

  logic [21:0]         ord_c;
  gocd_pkg::date_res_t s4;
  gocd_pkg::date_res_t dly [DLY];

  always_comb begin
    p_c       = year - 14'd1;
    prod100_c = 22'(p_c) * 22'(gocd_pkg::RCP_C100);
    prod400_c = 20'(p_c) * 20'(gocd_pkg::RCP_C400);
    ok_c      = (year != 14'd0) && (year <= 14'd9999) && (month != 4'd0) &&
                (month <= 4'd12) && (day != 5'd0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y1     <= year;
      m1     <= month;
      d1     <= day;
      p1     <= p_c;
      ok1    <= ok_c;
      q100e1 <= prod100_c[20:14];
      q400e1 <= prod400_c[18:14];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      y2     <= y1;
      m2     <= m1;
      d2     <= d1;
      p2     <= p1;
      ok2    <= ok1;
      q100e2 <= q100e1;
      q400e2 <= q400e1;
      r100_2 <= 8'(p1 - 14'(q100e1) * 14'd100);
      r400_2 <= 10'(p1 - 14'(q400e1) * 14'd400);
    end
  end

  always_comb begin
    c100_c  = r100_2 >= 8'd100;
    c400_c  = r400_2 >= 10'd400;
    r100_c  = c100_c ? r100_2 - 8'd100 : r100_2;
    r400_c  = c400_c ? r400_2 - 10'd400 : r400_2;
    leap_c  = (y2[1:0] == 2'b00) && ((r100_c != 8'd99) || (r400_c == 10'd399));
    mdays_c = (m2 == 4'd2 && leap_c) ? 5'd29 : gocd_pkg::month_len(m2);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      y3     <= y2;
      m3     <= m2;
      d3     <= d2;
      ok3    <= ok2 && (d2 <= mdays_c);
      q100_3 <= q100e2 + 7'(c100_c);
      q400_3 <= q400e2 + 5'(c400_c);
      q4_3   <= p2[13:2];
      p365_3 <= 22'(p2) * 22'd365;
      doy_3  <= 10'(gocd_pkg::month_start(m2)) + 10'(m2 > 4'd2 && leap_c) + 10'(d2);
    end
  end

  always_comb begin
    ord_c = p365_3 + 22'(q4_3) - 22'(q100_3) + 22'(q400_3) + 22'(doy_3);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4.err     <= !ok3;
      s4.ordinal <= ok3 ? ord_c : 22'd0;
      s4.year    <= ok3 ? y3 : 14'd0;
      s4.month   <= ok3 ? m3 : 4'd0;
      s4.day     <= ok3 ? d3 : 5'd0;
    end
  end

  for (genvar k = 0; k < DLY; k++) begin : g_dly
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[4]) begin
          dly[0] <= s4;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[k+4]) begin
          dly[k] <= dly[k-1];
        end
      end
    end
  end

  assign res = dly[DLY-1];

endmodule

// ----- rtl/gocd_o2d.sv -----
// ----------------------------------------------------------------------------
// Ordinal to date lane
// Splits the ordinal by the 400-, 100-, 4- and 1-year cycles with reciprocal
// estimates and one correction each, then finds month and day.
// ----------------------------------------------------------------------------
module gocd_o2d (
  input  logic                              clk,
  input  logic [gocd_pkg::LANE_DEPTH-1:0]   en,
  input  logic [21:0]                       ordinal,
  output gocd_pkg::date_res_t               res
);

  logic        bad_c;
  logic [21:0] n_c;
  logic [26:0] prod1_c;

  logic [21:0] o1, o2, o3, o4, o5, o6, o7, o8, o9;
  logic        bad1, bad2, bad3, bad4, bad5, bad6, bad7, bad8, bad9;

  logic [21:0] n1;
  logic [4:0]  q400e1, q400e2;
  logic [18:0] r2;

  logic        c3_c;
  logic [17:0] r3_c;
  logic [20:0] prod3_c;
  logic [4:0]  q400_3, q400_4, q400_5, q400_6, q400_7, q400_8;
  logic [17:0] r3;
  logic [2:0]  q100e3, q100e4;
  logic [16:0] r4;

  logic        c5_c;
  logic [15:0] r5_c;
  logic [20:0] prod5_c;
  logic [2:0]  q100_5, q100_6, q100_7, q100_8;
  logic [15:0] r5;
  logic [4:0]  q4e5, q4e6;
  logic [11:0] r6;

  logic        c7_c;
  logic [10:0] r7_c;
  logic [12:0] prod7_c;
  logic [4:0]  q4_7, q4_8;
  logic [10:0] r7;
  logic [1:0]  q1e7, q1e8;
  logic [9:0]  r8;

  logic        c9_c;
  logic [2:0]  q1_c;
  logic [8:0]  r9_c;
  logic [13:0] year_c;
  logic [13:0] year9;
  logic        dec9, lp9;
  logic [3:0]  m9;
  logic [8:0]  r9;

  logic [3:0]  mp_c, mf_c;
  logic [8:0]  bcur_c, bprev_c, bf_c;
  logic        back_c;

  always_comb begin
    bad_c   = (ordinal == 22'd0) || (ordinal > gocd_pkg::MAX_ORD);
    n_c     = ordinal - 22'd1;
    prod1_c = 27'(n_c) * 27'(gocd_pkg::RCP_400Y);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      o1     <= ordinal;
      bad1   <= bad_c;
      n1     <= n_c;
      q400e1 <= prod1_c[26:22];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      o2     <= o1;
      bad2   <= bad1;
      q400e2 <= q400e1;
      r2     <= 19'(n1 - 22'(q400e1) * 22'(gocd_pkg::DAYS_400Y));
    end
  end

  always_comb begin
    c3_c    = r2 >= 19'(gocd_pkg::DAYS_400Y);
    r3_c    = 18'(c3_c ? r2 - 19'(gocd_pkg::DAYS_400Y) : r2);
    prod3_c = 21'(r3_c) * 21'(gocd_pkg::RCP_100Y);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      o3     <= o2;
      bad3   <= bad2;
      q400_3 <= q400e2 + 5'(c3_c);
      r3     <= r3_c;
      q100e3 <= prod3_c[20:18];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      o4     <= o3;
      bad4   <= bad3;
      q400_4 <= q400_3;
      q100e4 <= q100e3;
      r4     <= 17'(r3 - 18'(q100e3) * 18'(gocd_pkg::DAYS_100Y));
    end
  end

  always_comb begin
    c5_c    = r4 >= 17'(gocd_pkg::DAYS_100Y);
    r5_c    = 16'(c5_c ? r4 - 17'(gocd_pkg::DAYS_100Y) : r4);
    prod5_c = 21'(r5_c) * 21'(gocd_pkg::RCP_4Y);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      o5     <= o4;
      bad5   <= bad4;
      q400_5 <= q400_4;
      q100_5 <= q100e4 + 3'(c5_c);
      r5     <= r5_c;
      q4e5   <= prod5_c[20:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      o6     <= o5;
      bad6   <= bad5;
      q400_6 <= q400_5;
      q100_6 <= q100_5;
      q4e6   <= q4e5;
      r6     <= 12'(r5 - 16'(q4e5) * 16'(gocd_pkg::DAYS_4Y));
    end
  end

  always_comb begin
    c7_c    = r6 >= 12'(gocd_pkg::DAYS_4Y);
    r7_c    = 11'(c7_c ? r6 - 12'(gocd_pkg::DAYS_4Y) : r6);
    prod7_c = 13'(r7_c) * 13'(gocd_pkg::RCP_1Y);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      o7     <= o6;
      bad7   <= bad6;
      q400_7 <= q400_6;
      q100_7 <= q100_6;
      q4_7   <= q4e6 + 5'(c7_c);
      r7     <= r7_c;
      q1e7   <= prod7_c[12:11];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      o8     <= o7;
      bad8   <= bad7;
      q400_8 <= q400_7;
      q100_8 <= q100_7;
      q4_8   <= q4_7;
      q1e8   <= q1e7;
      r8     <= 10'(r7 - 11'(q1e7) * 11'(gocd_pkg::DAYS_1Y));
    end
  end

  always_comb begin
    c9_c   = r8 >= 10'(gocd_pkg::DAYS_1Y);
    q1_c   = 3'(q1e8) + 3'(c9_c);
    r9_c   = 9'(c9_c ? r8 - 10'(gocd_pkg::DAYS_1Y) : r8);
    year_c = 14'(q400_8) * 14'd400 + 14'(q100_8) * 14'd100 + 14'(q4_8) * 14'd4 +
             14'(q1_c) + 14'd1;
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      o9    <= o8;
      bad9  <= bad8;
      year9 <= year_c;
      dec9  <= (q1_c == 3'd4) || (q100_8 == 3'd4);
      lp9   <= (q1_c == 3'd3) && ((q4_8 != 5'd24) || (q100_8 == 3'd3));
      r9    <= r9_c;
      m9    <= 4'((10'(r9_c) + 10'd50) >> 5);
    end
  end

  always_comb begin
    mp_c    = m9 - 4'd1;
    bcur_c  = gocd_pkg::month_start(m9) + 9'(m9 > 4'd2 && lp9);
    bprev_c = gocd_pkg::month_start(mp_c) + 9'(mp_c > 4'd2 && lp9);
    back_c  = (bcur_c > r9) && (m9 > 4'd1);
    mf_c    = back_c ? mp_c : m9;
    bf_c    = back_c ? bprev_c : bcur_c;
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      res.err <= bad9;
      if (bad9) begin
        res.ordinal <= 22'd0;
        res.year    <= 14'd0;
        res.month   <= 4'd0;
        res.day     <= 5'd0;
      end else if (dec9) begin
        res.ordinal <= o9;
        res.year    <= year9 - 14'd1;
        res.month   <= 4'd12;
        res.day     <= 5'd31;
      end else begin
        res.ordinal <= o9;
        res.year    <= year9;
        res.month   <= mf_c;
        res.day     <= 5'(r9 - bf_c + 9'd1);
      end
    end
  end

endmodule

// ----- rtl/gocd_wday.sv -----
// ----------------------------------------------------------------------------
// Result merge and weekday stages
// Selects the lane of the request's mode, sets the status and computes
// (ordinal + 6) mod 7 by reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module gocd_wday (
  input  logic                             clk,
  input  logic [gocd_pkg::OUT_DEPTH-1:0]   en,
  input  logic                             mode,
  input  gocd_pkg::date_res_t              d2o,
  input  gocd_pkg::date_res_t              o2d,
  output logic [21:0]                      ordinal,
  output logic [13:0]                      year,
  output logic [3:0]                       month,
  output logic [4:0]                       day,
  output logic [2:0]                       weekday,
  output gocd_pkg::status_t                status
);

  gocd_pkg::date_res_t sel_c, r1, r2;
  gocd_pkg::status_t   st_c, st1, st2;
  logic [21:0]         x1, x2;
  logic [41:0]         prod_c;
  logic [19:0]         qe2;
  logic [3:0]          rr_c;
  logic [2:0]          wd_c;

  always_comb begin
    sel_c = mode ? o2d : d2o;
    if (sel_c.err) begin
      st_c = mode ? gocd_pkg::ST_BAD_ORD : gocd_pkg::ST_BAD_DATE;
    end else begin
      st_c = gocd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r1  <= sel_c;
      st1 <= st_c;
      x1  <= sel_c.ordinal + 22'd6;
    end
  end

  assign prod_c = 42'(x1) * 42'(gocd_pkg::RCP_WEEK);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r2  <= r1;
      st2 <= st1;
      x2  <= x1;
      qe2 <= prod_c[41:22];
    end
  end

  always_comb begin
    rr_c = 4'(x2 - 22'(qe2) * 22'd7);
    wd_c = 3'((rr_c >= 4'd7) ? rr_c - 4'd7 : rr_c);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ordinal <= r2.ordinal;
      year    <= r2.year;
      month   <= r2.month;
      day     <= r2.day;
      weekday <= (st2 == gocd_pkg::ST_OK) ? wd_c : 3'd0;
      status  <= st2;
    end
  end

endmodule

// ----- test/gregorian_ordinal_date_convert_check.sv -----
// ----------------------------------------------------------------------------
// Gregorian ordinal date converter checker
// Watches both stream channels, computes the expected conversion for every
// accepted request, and compares each accepted result against the oldest one.
// ----------------------------------------------------------------------------
package gocd_test_pkg;

  import gocd_pkg::status_t;

  localparam int unsigned LAST_ORDINAL = 3652059;

  typedef enum logic {
    MODE_DATE_TO_ORD = 1'b0,
    MODE_ORD_TO_DATE = 1'b1
  } conv_mode_t;

  typedef struct packed {
    conv_mode_t  mode;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] ordinal;
  } conv_req_t;

  typedef struct packed {
    logic [21:0] ordinal;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    status_t     status;
  } conv_res_t;

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    case (m)
      2: begin
        return is_leap(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      1, 3, 5, 7, 8, 10, 12: begin
        return 31;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

endpackage

module gregorian_ordinal_date_convert_check
  import gocd_pkg::*;
  import gocd_test_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          mismatch_count,
  output int          outstanding
);

  conv_res_t expected_dates[$];
  int        mismatches = 0;

  function automatic int unsigned days_before_year(int unsigned y);
    int unsigned p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic conv_res_t convert_request(conv_req_t r);
    conv_res_t   res;
    int unsigned y, m, d, n, ord, c400, c100, c4, c1;
    res = '0;
    res.status = ST_OK;
    if (r.mode == MODE_DATE_TO_ORD) begin
      y = r.year;
      m = r.month;
      d = r.day;
      if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1 || d > month_length(y, m)) begin
        res.status = ST_BAD_DATE;
      end else begin
        ord = days_before_year(y) + d;
        for (int k = 1; k < m; k++) begin
          ord += month_length(y, k);
        end
        res.ordinal = 22'(ord);
        res.year = r.year;
        res.month = r.month;
        res.day = r.day;
      end
    end else begin
      ord = r.ordinal;
      if (ord < 1 || ord > LAST_ORDINAL) begin
        res.status = ST_BAD_ORD;
      end else begin
        n = ord - 1;
        c400 = n / 146097;
        n = n % 146097;
        c100 = (n / 36524 > 3) ? 3 : n / 36524;
        n = n - c100 * 36524;
        c4 = n / 1461;
        n = n - c4 * 1461;
        c1 = (n / 365 > 3) ? 3 : n / 365;
        n = n - c1 * 365;
        y = c400 * 400 + c100 * 100 + c4 * 4 + c1 + 1;
        m = 1;
        while (n >= month_length(y, m)) begin
          n -= month_length(y, m);
          m++;
        end
        res.ordinal = r.ordinal;
        res.year = 14'(y);
        res.month = 4'(m);
        res.day = 5'(n + 1);
      end
    end
    if (res.status == ST_OK) begin
      res.weekday = 3'((ord + 6) % 7);
    end
    return res;
  endfunction

  function automatic int field_diff(string name, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    conv_res_t exp_date;
    conv_req_t req;
    int        bad;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_dates.size() == 0) begin
          $error("result with no request outstanding: tdata %h tuser %h", m_tdata, m_tuser);
          mismatches++;
        end else begin
          exp_date = expected_dates.pop_front();
          bad = 0;
          bad += field_diff("out_ordinal", exp_date.ordinal, m_tdata[21:0]);
          bad += field_diff("out_year", exp_date.year, m_tdata[35:22]);
          bad += field_diff("out_month", exp_date.month, m_tdata[39:36]);
          bad += field_diff("out_day", exp_date.day, m_tdata[44:40]);
          bad += field_diff("out_weekday", exp_date.weekday, m_tdata[47:45]);
          bad += field_diff("status", exp_date.status, m_tuser);
          if (bad != 0) begin
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req.mode = conv_mode_t'(s_tuser[0]);
        req.year = s_tdata[13:0];
        req.month = s_tdata[17:14];
        req.day = s_tdata[22:18];
        req.ordinal = s_tdata[44:23];
        expected_dates.push_back(convert_request(req));
      end
    end
    mismatch_count <= mismatches;
    outstanding <= expected_dates.size();
  end

endmodule

// ----- test/gregorian_ordinal_date_convert_test.sv -----
// ----------------------------------------------------------------------------
// Gregorian ordinal date converter testbench
// Drives directed calendar edge cases and then random dates and ordinals in
// both modes, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module gregorian_ordinal_date_convert_test;

  import gocd_pkg::*;
  import gocd_test_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_REQS    = 1425;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_STARVED
  } rx_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  int        mismatch_count;
  int        outstanding;
  int        burst_left = 0;
  int        stall_cycles = 0;
  int        rx_left = 0;
  rx_style_t rx_style = RX_OPEN;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gregorian_ordinal_date_convert uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  gregorian_ordinal_date_convert_check chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style <= rx_style_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(5, 80);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_style)
        RX_OPEN: begin
          m_tready <= 1'b1;
        end
        RX_COIN: begin
          m_tready <= $urandom_range(0, 1);
        end
        RX_MOSTLY: begin
          m_tready <= ($urandom_range(0, 7) != 0);
        end
        default: begin
          m_tready <= ($urandom_range(0, 9) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || !(s_tvalid || outstanding != 0) || (s_tvalid && s_tready) ||
        (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic conv_req_t date_req(int unsigned y, int unsigned m, int unsigned d);
    conv_req_t r;
    r.mode = MODE_DATE_TO_ORD;
    r.year = 14'(y);
    r.month = 4'(m);
    r.day = 5'(d);
    r.ordinal = 22'($urandom);
    return r;
  endfunction

  function automatic conv_req_t ord_req(int unsigned n);
    conv_req_t r;
    r.mode = MODE_ORD_TO_DATE;
    r.year = 14'($urandom);
    r.month = 4'($urandom);
    r.day = 5'($urandom);
    r.ordinal = 22'(n);
    return r;
  endfunction

  task automatic send_req(input conv_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 4);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, r.ordinal, r.day, r.month, r.year};
    s_tuser <= r.mode;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    int unsigned sel, y, m, span, n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_req(date_req(1, 1, 1));
    send_req(date_req(9999, 12, 31));
    send_req(date_req(2000, 2, 29));
    send_req(date_req(1900, 2, 29));
    send_req(date_req(2004, 2, 29));
    send_req(date_req(2001, 2, 29));
    send_req(date_req(2100, 2, 28));
    send_req(date_req(0, 1, 1));
    send_req(date_req(10000, 1, 1));
    send_req(date_req(16383, 15, 31));
    send_req(date_req(2023, 0, 10));
    send_req(date_req(2023, 13, 1));
    send_req(date_req(2023, 4, 31));
    send_req(date_req(2023, 4, 0));
    send_req(date_req(2024, 12, 31));
    send_req(ord_req(0));
    send_req(ord_req(1));
    send_req(ord_req(LAST_ORDINAL));
    send_req(ord_req(LAST_ORDINAL + 1));
    send_req(ord_req(4194303));
    send_req(ord_req(146097));
    send_req(ord_req(1461));
    send_req(ord_req(36524));
    send_req(ord_req(730179));
    send_req(ord_req(59));
    send_req(ord_req(60));

    repeat (RANDOM_REQS) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        y = ($urandom_range(0, 4) == 0) ? 100 * $urandom_range(1, 99) : $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        send_req(date_req(y, m, $urandom_range(1, month_length(y, m))));
      end else if (sel < 55) begin
        send_req(date_req($urandom_range(0, 16383), $urandom_range(0, 15),
                          $urandom_range(0, 31)));
      end else if (sel < 60) begin
        y = ($urandom_range(0, 1) == 0) ? 4 * $urandom_range(1, 2499) : $urandom_range(1, 9999);
        case ($urandom_range(0, 2))
          0: begin
            send_req(date_req(y, 2, $urandom_range(28, 30)));
          end
          1: begin
            send_req(date_req(y, 12, 31));
          end
          default: begin
            send_req(date_req(y, 1, 1));
          end
        endcase
      end else if (sel < 88) begin
        send_req(ord_req($urandom_range(1, LAST_ORDINAL)));
      end else if (sel < 95) begin
        case ($urandom_range(0, 3))
          0: begin
            span = 146097;
          end
          1: begin
            span = 36524;
          end
          2: begin
            span = 1461;
          end
          default: begin
            span = 365;
          end
        endcase
        n = $urandom_range(1, LAST_ORDINAL / span + 1) * span + $urandom_range(0, 4) - 2;
        send_req(ord_req(n));
      end else begin
        send_req(ord_req($urandom_range(0, 4194303)));
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
